// File: rtl/core/arx_permutation_128_assert.svh
// ----------------------------------------------------------------------------
// ARX permutation assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ARX_PERMUTATION_128_ASSERT_SVH
`define ARX_PERMUTATION_128_ASSERT_SVH

`ifndef SYNTHESIS

// The expression must hold at every clock edge outside reset.
`define ARX128_ASSERT_HOLD(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: expression does not hold");

// The consequent must hold whenever the antecedent holds at the same edge.
`define ARX128_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication violated");

`else

`define ARX128_ASSERT_HOLD(label, clk, rst, expr)
`define ARX128_ASSERT_IMPLIES(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/core/arx128_pkg.sv
// ----------------------------------------------------------------------------
// ARX permutation package
// Shared types, rotation amounts and step functions for the pipeline stages.
// ----------------------------------------------------------------------------
package arx128_pkg;

   localparam int unsigned WORD_WIDTH   = 32;
   localparam int unsigned ROUND_COUNT  = 2;
   localparam int unsigned STAGES_PER_ROUND = 3;
   localparam int unsigned PIPE_LATENCY = ROUND_COUNT * STAGES_PER_ROUND;

   // Rotation amounts of the horizontal and vertical steps.
   localparam int unsigned ROT_H_A = 1;
   localparam int unsigned ROT_H_B = 2;
   localparam int unsigned ROT_H_C = 5;
   localparam int unsigned ROT_H_D = 7;
   localparam int unsigned ROT_V_A = 11;
   localparam int unsigned ROT_V_B = 13;
   localparam int unsigned ROT_V_C = 17;
   localparam int unsigned ROT_V_D = 19;

   typedef logic [WORD_WIDTH-1:0] word_type;

   typedef struct packed {
      logic     valid;
      word_type a;
      word_type b;
      word_type c;
      word_type d;
   } stage_type;

   function automatic word_type rotl(input word_type x, input int unsigned amount);
      word_type result;
      result = (x << amount) | (x >> (WORD_WIDTH - amount));
      return result;
   endfunction

   // Bitwise choice: takes one where sel is set, zero elsewhere.
   function automatic word_type choose(input word_type sel, input word_type one,
                                       input word_type zero);
      word_type result;
      result = zero ^ (sel & (one ^ zero));
      return result;
   endfunction

endpackage

// File: rtl/core/arx_permutation_128.sv
// ----------------------------------------------------------------------------
// ARX permutation, 128-bit block
// Fully pipelined permutation of four 32-bit words over ROUND_COUNT rounds.
// ----------------------------------------------------------------------------
// A block is taken on every clock edge at which start is high and busy is
// low, one transaction per cycle with no gaps needed between them. Busy is
// high during reset and in the first cycle after it, and for nothing else,
// so once busy has fallen the block takes a transaction in
// every cycle. Each transaction, having passed the register stages of
// all ROUND_COUNT rounds in turn, comes back on the rsp_ ports,
// marked by rsp_valid for a single cycle; results leave in the order the
// blocks arrived. Every round occupies three register stages: one for the
// horizontal add-xor-rotate steps of words a and b, one for those of words
// c and d, and one for the four vertical choice-xor-rotate steps. The two
// chained 32-bit adds of a horizontal stage set the clock period. Since the
// receiver cannot hold results off, there is no back-pressure: a valid bit
// moves with every block through the stages and nothing is ever stalled.
// ----------------------------------------------------------------------------
`include "arx_permutation_128_assert.svh"

module arx_permutation_128 (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  arx128_pkg::word_type req_word_in_a,
   input  arx128_pkg::word_type req_word_in_b,
   input  arx128_pkg::word_type req_word_in_c,
   input  arx128_pkg::word_type req_word_in_d,
   output logic                 rsp_valid,
   output arx128_pkg::word_type rsp_word_out_a,
   output arx128_pkg::word_type rsp_word_out_b,
   output arx128_pkg::word_type rsp_word_out_c,
   output arx128_pkg::word_type rsp_word_out_d
);
   import arx128_pkg::*;

   // Busy is held during reset and in the cycle after it, so that no
   // transaction is taken while the pipeline valid bits are being cleared.
   logic busy_ff;
   logic busy_in;

   // Stage boundaries: entry 0 is the request port, the last entry the
   // output register of the final vertical stage.
   stage_type pipe [0:PIPE_LATENCY];

   assign busy_in = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;

   always_comb begin
      pipe[0].valid = start & ~busy_ff;
      pipe[0].a     = req_word_in_a;
      pipe[0].b     = req_word_in_b;
      pipe[0].c     = req_word_in_c;
      pipe[0].d     = req_word_in_d;
   end

   // One group of three stages for each round.
   for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
      arx128_hadd_ab u_hadd_ab (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (pipe[r*STAGES_PER_ROUND]),
         .stage_out (pipe[r*STAGES_PER_ROUND + 1])
      );

      arx128_hadd_cd u_hadd_cd (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (pipe[r*STAGES_PER_ROUND + 1]),
         .stage_out (pipe[r*STAGES_PER_ROUND + 2])
      );

      arx128_vmix u_vmix (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (pipe[r*STAGES_PER_ROUND + 2]),
         .stage_out (pipe[r*STAGES_PER_ROUND + 3])
      );
   end

   assign rsp_valid      = pipe[PIPE_LATENCY].valid;
   assign rsp_word_out_a = pipe[PIPE_LATENCY].a;
   assign rsp_word_out_b = pipe[PIPE_LATENCY].b;
   assign rsp_word_out_c = pipe[PIPE_LATENCY].c;
   assign rsp_word_out_d = pipe[PIPE_LATENCY].d;

   // Every response traces back to a request exactly the pipeline depth ago.
   `ARX128_ASSERT_IMPLIES(a_rsp_has_req, clock, reset, rsp_valid, $past(start && !busy, PIPE_LATENCY))
   // Outside reset, busy is high only in the first cycle after reset.
   `ARX128_ASSERT_HOLD(a_ready_after_reset, clock, reset, busy == $past(reset))
   // Reset flushes every stage, so no stale response follows it.
   `ARX128_ASSERT_IMPLIES(a_flush_on_reset, clock, reset, $fell(reset), !rsp_valid)

endmodule

// File: rtl/core/arx128_hadd_ab.sv
// ----------------------------------------------------------------------------
// ARX horizontal stage, words a and b
// Registers the first two add-xor-rotate steps of a round.
// ----------------------------------------------------------------------------
module arx128_hadd_ab (
   input  logic                  clock,
   input  logic                  reset,
   input  arx128_pkg::stage_type stage_in,
   output arx128_pkg::stage_type stage_out
);
   import arx128_pkg::*;

   stage_type stage_ff;
   stage_type stage_in_next;
   word_type  a_new;
   word_type  b_new;

   always_comb begin
      a_new = rotl(stage_in.a + (stage_in.b ^ stage_in.c ^ stage_in.d), ROT_H_A);
      b_new = rotl(stage_in.b + (a_new ^ stage_in.c ^ stage_in.d), ROT_H_B);
      stage_in_next       = stage_in;
      stage_in_next.a     = a_new;
      stage_in_next.b     = b_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in_next;
      end
   end

   assign stage_out = stage_ff;

endmodule

// File: rtl/core/arx128_hadd_cd.sv
// ----------------------------------------------------------------------------
// ARX horizontal stage, words c and d
// Registers the last two add-xor-rotate steps of a round.
// ----------------------------------------------------------------------------
module arx128_hadd_cd (
   input  logic                  clock,
   input  logic                  reset,
   input  arx128_pkg::stage_type stage_in,
   output arx128_pkg::stage_type stage_out
);
   import arx128_pkg::*;

   stage_type stage_ff;
   stage_type stage_in_next;
   word_type  c_new;
   word_type  d_new;

   always_comb begin
      c_new = rotl(stage_in.c + (stage_in.a ^ stage_in.b ^ stage_in.d), ROT_H_C);
      d_new = rotl(stage_in.d + (stage_in.a ^ stage_in.b ^ c_new), ROT_H_D);
      stage_in_next   = stage_in;
      stage_in_next.c = c_new;
      stage_in_next.d = d_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in_next;
      end
   end

   assign stage_out = stage_ff;

endmodule

// File: rtl/core/arx128_vmix.sv
// ----------------------------------------------------------------------------
// ARX vertical stage
// Registers the four choice-xor-rotate steps that close a round.
// ----------------------------------------------------------------------------
module arx128_vmix (
   input  logic                  clock,
   input  logic                  reset,
   input  arx128_pkg::stage_type stage_in,
   output arx128_pkg::stage_type stage_out
);
   import arx128_pkg::*;

   stage_type stage_ff;
   word_type  a_new;
   word_type  b_new;
   word_type  c_new;
   word_type  d_new;

   // Pure bitwise logic, so all four dependent steps fit in one stage.
   always_comb begin
      a_new = rotl(stage_in.a ^ choose(stage_in.b, stage_in.c, stage_in.d), ROT_V_A);
      b_new = rotl(stage_in.b ^ choose(a_new, stage_in.c, stage_in.d), ROT_V_B);
      c_new = rotl(stage_in.c ^ choose(a_new, b_new, stage_in.d), ROT_V_C);
      d_new = rotl(stage_in.d ^ choose(a_new, b_new, c_new), ROT_V_D);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff.valid <= stage_in.valid;
         stage_ff.a     <= a_new;
         stage_ff.b     <= b_new;
         stage_ff.c     <= c_new;
         stage_ff.d     <= d_new;
      end
   end

   assign stage_out = stage_ff;

endmodule
